@@ design/lru_stack_page_replacement_macros.svh @@
// ----------------------------------------------------------------------------
// lru_stack_page_replacement_macros.svh
// assertion macros used by the checker file of the lru stack block
// ----------------------------------------------------------------------------
`ifndef LRU_STACK_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_STACK_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsp same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define LSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsp next-cycle check failed");

`endif

@@ design/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// shared types and constants of the lru stack page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int PAGE_W     = 16;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_TOP,
    ST_FINISH
  } lsp_state_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [FAULT_W-1:0]   fault_total;
  } lsp_result_t;

endpackage

`default_nettype wire

@@ design/lsp_ram.sv @@
// ----------------------------------------------------------------------------
// lsp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ design/lsp_engine.sv @@
// ----------------------------------------------------------------------------
// lsp_engine
// sequencer that walks the recency stack with one comparator and one ram
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_engine #(
  parameter int FRAMES = lsp_pkg::FRAMES_DEF,
  localparam int CW = $clog2(FRAMES + 1),
  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lsp_pkg::PAGE_W-1:0] page_in,
  input  logic [CW-1:0]             frames,
  output logic                      idle,
  output logic                      res_valid,
  output lsp_pkg::lsp_result_t      res,
  input  logic                      res_take
);

  lsp_pkg::lsp_state_t state_r, state_nxt;

  logic [lsp_pkg::PAGE_W-1:0]  page_r, page_nxt;
  logic [lsp_pkg::PAGE_W-1:0]  ev_r, ev_nxt;
  logic [lsp_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] cmp_a_r, cmp_a_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;
  logic [CW-1:0] wr_i_r, wr_i_nxt;
  logic [AW-1:0] top_a_r, top_a_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          wv_r, wv_nxt;
  logic          hit_r, hit_nxt;
  logic          evv_r, evv_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [lsp_pkg::PAGE_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [lsp_pkg::PAGE_W-1:0] ram_rdata;

  logic match, exhausted, shift_done, room;

  lsp_ram #(
    .WIDTH (lsp_pkg::PAGE_W),
    .DEPTH (FRAMES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the shared comparator
  assign match      = cmp_v_r && (ram_rdata == page_r);
  assign exhausted  = !cmp_v_r && (scan_r == count_r);
  assign shift_done = !wv_r && (rd_i_r >= count_r);
  assign room       = count_r < frames;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lsp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = lsp_pkg::ST_SEARCH;
        end
      end
      lsp_pkg::ST_SEARCH: begin
        if (match) begin
          state_nxt = lsp_pkg::ST_SHIFT;
        end else if (exhausted) begin
          state_nxt = room ? lsp_pkg::ST_TOP : lsp_pkg::ST_SHIFT;
        end
      end
      lsp_pkg::ST_SHIFT: begin
        if (shift_done) begin
          state_nxt = lsp_pkg::ST_TOP;
        end
      end
      lsp_pkg::ST_TOP: begin
        state_nxt = lsp_pkg::ST_FINISH;
      end
      lsp_pkg::ST_FINISH: begin
        if (res_take) begin
          state_nxt = lsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    page_nxt  = page_r;
    ev_nxt    = ev_r;
    fault_nxt = fault_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    cmp_a_nxt = cmp_a_r;
    cmp_v_nxt = 1'b0;
    rd_i_nxt  = rd_i_r;
    wr_i_nxt  = wr_i_r;
    wv_nxt    = 1'b0;
    top_a_nxt = top_a_r;
    hit_nxt   = hit_r;
    evv_nxt   = evv_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = page_r;
    ram_raddr = '0;
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      lsp_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          page_nxt = page_in;
          scan_nxt = '0;
        end
      end
      lsp_pkg::ST_SEARCH: begin
        // read of the next entry overlaps the compare of the previous one
        if (scan_r < count_r) begin
          ram_raddr = scan_r[AW-1:0];
          scan_nxt  = scan_r + CW'(1);
          cmp_a_nxt = scan_r;
          cmp_v_nxt = 1'b1;
        end
        // keep the least recent page in case this turns into an eviction
        if (cmp_v_r && (cmp_a_r == '0)) begin
          ev_nxt = ram_rdata;
        end
        if (match) begin
          hit_nxt   = 1'b1;
          evv_nxt   = 1'b0;
          rd_i_nxt  = cmp_a_r + CW'(1);
          top_a_nxt = AW'(count_r - CW'(1));
          cmp_v_nxt = 1'b0;
        end else if (exhausted) begin
          hit_nxt  = 1'b0;
          rd_i_nxt = CW'(1);
          if (fault_r != '1) begin
            fault_nxt = fault_r + lsp_pkg::FAULT_W'(1);
          end
          if (room) begin
            evv_nxt   = 1'b0;
            top_a_nxt = AW'(count_r);
            count_nxt = count_r + CW'(1);
          end else begin
            evv_nxt   = 1'b1;
            top_a_nxt = AW'(count_r - CW'(1));
          end
        end
      end
      lsp_pkg::ST_SHIFT: begin
        // entry i+1 is read, then written to entry i in the next cycle
        if (wv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_i_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (rd_i_r < count_r) begin
          ram_raddr = rd_i_r[AW-1:0];
          rd_i_nxt  = rd_i_r + CW'(1);
          wr_i_nxt  = rd_i_r - CW'(1);
          wv_nxt    = 1'b1;
        end
      end
      lsp_pkg::ST_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = top_a_r;
        ram_wdata = page_r;
      end
      lsp_pkg::ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  assign res.hit           = hit_r;
  assign res.evicted_valid = evv_r;
  assign res.evicted_page  = evv_r ? ev_r : '0;
  assign res.fault_total   = fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsp_pkg::ST_IDLE;
      count_r <= '0;
      fault_r <= '0;
      cmp_v_r <= 1'b0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fault_r <= fault_nxt;
      cmp_v_r <= cmp_v_nxt;
      wv_r    <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    ev_r    <= ev_nxt;
    scan_r  <= scan_nxt;
    cmp_a_r <= cmp_a_nxt;
    rd_i_r  <= rd_i_nxt;
    wr_i_r  <= wr_i_nxt;
    top_a_r <= top_a_nxt;
    hit_r   <= hit_nxt;
    evv_r   <= evv_nxt;
  end

endmodule

`default_nettype wire

@@ design/lru_stack_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_stack_page_replacement
// lru page replacement over a recency stack held in a small ram
// ----------------------------------------------------------------------------
// One page reference is taken per transaction and answered with one result:
// hit, the evicted page (when a resident page had to go) and the saturating
// fault total. The resident pages sit in a ram ordered least to most recently
// used; one comparator walks them one entry per cycle, then the same ram
// shifts the entries above the hit or evicted slot down by one, one entry per
// cycle. A reference goes through the search, the shift on a hit or an
// eviction, a write of the new top entry and the hand-over of the result;
// an append skips the shift. The walk and the shift are paced by the single
// comparator and the one read and one write port of the stack ram.
// in_ready is high only while no reference is in progress, so the next
// transaction can go in the cycle after the result is handed over; a finished
// result waits in the output register, and the engine holds the next one
// while that register is still full.
// frame_count is written through cfg_wr_en/cfg_wr_data (zero acts as one
// frame, values above FRAMES act as FRAMES).
// ----------------------------------------------------------------------------
`default_nettype none

module lru_stack_page_replacement #(
  parameter int FRAMES = lsp_pkg::FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lsp_pkg::PAGE_W-1:0]  in_page_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic                        out_evicted_valid,
  output logic [lsp_pkg::PAGE_W-1:0]  out_evicted_page,
  output logic [lsp_pkg::FAULT_W-1:0] out_fault_total,
  input  logic                        cfg_wr_en,
  input  logic [lsp_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int CW = $clog2(FRAMES + 1);
  localparam int EW = (CW > lsp_pkg::CFG_W) ? CW : lsp_pkg::CFG_W;

  logic [lsp_pkg::CFG_W-1:0] frame_count_r;
  logic [EW-1:0]             cfg_ext;
  logic [EW-1:0]             frames_e;
  logic [CW-1:0]             frames;

  logic                 eng_idle;
  logic                 res_valid;
  lsp_pkg::lsp_result_t res;
  logic                 res_take;

  logic                 out_valid_r;
  lsp_pkg::lsp_result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= lsp_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      frame_count_r <= cfg_wr_data;
    end
  end

  // clamp the configured count into 1..FRAMES
  assign cfg_ext  = EW'(frame_count_r);
  assign frames_e = (cfg_ext == '0) ? EW'(1) :
                    (cfg_ext > EW'(FRAMES)) ? EW'(FRAMES) : cfg_ext;
  assign frames   = CW'(frames_e);

  assign in_ready = eng_idle;
  assign res_take = !out_valid_r || out_ready;

  lsp_engine #(
    .FRAMES (FRAMES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .page_in   (in_page_number),
    .frames    (frames),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_evicted_valid = out_r.evicted_valid;
  assign out_evicted_page  = out_r.evicted_page;
  assign out_fault_total   = out_r.fault_total;

endmodule

`default_nettype wire

@@ design/lsp_checker.sv @@
// ----------------------------------------------------------------------------
// lsp_checker
// port-level checks of the lru stack block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_stack_page_replacement_macros.svh"

module lsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic                        out_evicted_valid,
  input logic [lsp_pkg::PAGE_W-1:0]  out_evicted_page,
  input logic [lsp_pkg::FAULT_W-1:0] out_fault_total
);

  // a hit never evicts
  `LSP_ASSERT_SAME(a_hit_no_evict, out_valid && out_hit, !out_evicted_valid)

  // evicted page reads zero when nothing was evicted
  `LSP_ASSERT_SAME(a_evict_zero, out_valid && !out_evicted_valid, out_evicted_page == '0)

  // a fault has been counted by the time its transaction is shown
  `LSP_ASSERT_SAME(a_fault_counted, out_valid && !out_hit, out_fault_total != '0)

  // one reference at a time: ready drops after an accepted transaction
  `LSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `LSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fault_total))

endmodule

bind lru_stack_page_replacement lsp_checker u_lsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total)
);

`default_nettype wire
